FILE: rtl/white_blob_centroid_steer_unit_assert.svh
// Assertion macros for the centroid steering block.
// WBCS_ASSERT_NOW  : when cond holds, prop holds in the same cycle.
// WBCS_ASSERT_NEXT : when cond holds, prop holds in the next cycle.
`ifndef WHITE_BLOB_CENTROID_STEER_UNIT_ASSERT_SVH
`define WHITE_BLOB_CENTROID_STEER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WBCS_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("wbcs assertion failed");
`define WBCS_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("wbcs assertion failed");
`else
`define WBCS_ASSERT_NOW(label, clk, rstn, cond, prop)
`define WBCS_ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif
`endif

FILE: rtl/wbcs_pkg.sv
package wbcs_pkg;

    // Frame dimension width and the widths that follow from it
    localparam int DIM_BITS = 12;
    localparam int IDX_W    = 2 * DIM_BITS;
    localparam int SUM_W    = 3 * DIM_BITS;

    // Fixed field widths
    localparam int CH_W      = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W     = 2;
    localparam int MEAN_W    = 12;
    localparam int COUNT_W   = 24;

    localparam logic [CH_W-1:0] WHITE_LEVEL = 8'hFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    // Steering codes
    localparam logic [DIR_W-1:0] DIR_STOP     = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_STRAIGHT = 2'd3;

    // Pixel queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Step counter of the serial mean divider, one step per sum bit
    localparam int STEP_W = $clog2(SUM_W + 1);

    // Divide by three through a reciprocal: exact for inputs below 2^(DIV3_SHIFT-1)
    localparam int DIV3_IN_W  = IDX_W + 1;
    localparam int DIV3_SHIFT = DIV3_IN_W + 2;
    localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP =
        DIV3_SHIFT'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    function automatic logic [IDX_W-1:0] div3(input logic [DIV3_IN_W-1:0] x);
        logic [DIV3_IN_W+DIV3_SHIFT-1:0] prod;
        prod = {{DIV3_SHIFT{1'b0}}, x} * {{DIV3_IN_W{1'b0}}, DIV3_RECIP};
        return IDX_W'(prod >> DIV3_SHIFT);
    endfunction

    // Settled configuration and derived thresholds
    typedef struct packed {
        logic                busy;
        logic [DIM_BITS-1:0] width;
        logic [IDX_W-1:0]    band_lo;
        logic [IDX_W-1:0]    band_hi;
        logic [DIM_BITS-1:0] width_lo;
        logic [DIM_BITS-1:0] width_hi;
    } cfg_status_t;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic                hit;
        logic [DIM_BITS-1:0] column;
        logic                last;
    } pixel_t;

endpackage

FILE: rtl/white_blob_centroid_steer_unit.sv
// White blob centroid steering. Pixels arrive in raster order, one per stream transaction, and
// are taken at one per clock while the queue has room and the thresholds are not being
// recomputed. Each pixel in the middle third of the frame that is pure white adds its column to
// a running sum; the transaction with tlast set closes the frame and yields one result
// (direction code, mean column, white count). m_tvalid rises once the tlast transaction has
// been popped and the bit-serial divider in the back end has finished. While the divider runs,
// a four-entry pixel queue keeps input flowing; once it fills, input stalls until the division
// is done, and longer while the previous result still waits on m_tready. A write to
// image_width or image_height, and reset, hold s_tready low while the band and steering
// thresholds are recomputed.
`include "white_blob_centroid_steer_unit_assert.svh"

module white_blob_centroid_steer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // red, green, blue
    input  logic                              s_tlast,   // frame_end
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // direction, mean_column,
                                                         // white_count, zero pad
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbcs_pkg::CFG_W-1:0]        cfg_data
);

    wbcs_pkg::cfg_status_t              status;
    wbcs_pkg::pixel_t                   push_item;
    wbcs_pkg::pixel_t                   q_head;
    logic                               q_push;
    logic                               q_pop;
    logic                               q_full;
    logic                               q_empty;
    logic [wbcs_pkg::DIR_W-1:0]         res_dir;
    logic [wbcs_pkg::MEAN_W-1:0]        res_mean;
    logic [wbcs_pkg::COUNT_W-1:0]       res_count;

    // Configuration registers and thresholds
    wbcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status)
    );

    // Pixel intake and classification
    wbcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .frame_end (s_tlast),
        .status    (status),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // Queue between front and back
    wbcs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Accumulation, division and steering decision
    wbcs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .direction   (res_dir),
        .mean_column (res_mean),
        .white_count (res_count)
    );

    assign m_tdata = {2'b00, res_count, res_mean, res_dir};

    // Checks
    `WBCS_ASSERT_NOW(a_stop_iff_none, aclk, aresetn, m_tvalid,
        ((res_dir == wbcs_pkg::DIR_STOP) == (res_count == '0)))
    `WBCS_ASSERT_NOW(a_stop_mean_zero, aclk, aresetn,
        m_tvalid && (res_dir == wbcs_pkg::DIR_STOP), (res_mean == '0))
    `WBCS_ASSERT_NOW(a_settle_blocks_input, aclk, aresetn, status.busy, !s_tready)
    `WBCS_ASSERT_NEXT(a_push_lands, aclk, aresetn, q_push, !q_empty)

endmodule

FILE: rtl/wbcs_cfg.sv
module wbcs_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbcs_pkg::CFG_W-1:0]        cfg_data,
    output wbcs_pkg::cfg_status_t             status
);

    typedef enum logic [2:0] {
        SET_IDLE,
        SET_PROD,
        SET_LO,
        SET_HI,
        SET_WLO,
        SET_WHI
    } set_state_t;

    set_state_t                         state_reg;
    logic [wbcs_pkg::DIM_BITS-1:0]      width_reg;
    logic [wbcs_pkg::DIM_BITS-1:0]      height_reg;
    logic [wbcs_pkg::IDX_W-1:0]         total_reg;
    logic [wbcs_pkg::IDX_W-1:0]         band_lo_reg;
    logic [wbcs_pkg::IDX_W-1:0]         band_hi_reg;
    logic [wbcs_pkg::DIM_BITS-1:0]      width_lo_reg;
    logic [wbcs_pkg::DIM_BITS-1:0]      width_hi_reg;

    logic [wbcs_pkg::DIV3_IN_W-1:0]     div3_in;
    logic [wbcs_pkg::IDX_W-1:0]         div3_out;
    logic                               wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Shared divide-by-three operand select
    always_comb begin
        case (state_reg)
            SET_LO:  div3_in = {1'b0, total_reg};
            SET_HI:  div3_in = {total_reg, 1'b0};
            SET_WLO: div3_in = wbcs_pkg::DIV3_IN_W'(width_reg);
            SET_WHI: div3_in = wbcs_pkg::DIV3_IN_W'({width_reg, 1'b0});
            default: div3_in = '0;
        endcase
        div3_out = wbcs_pkg::div3(div3_in);
    end

    // Register writes and threshold sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= wbcs_pkg::WIDTH_RESET;
            height_reg <= wbcs_pkg::HEIGHT_RESET;
            state_reg  <= SET_PROD;
        end else if (wr_en) begin
            case (cfg_index)
                wbcs_pkg::REG_WIDTH:  width_reg  <= wbcs_pkg::DIM_BITS'(cfg_data);
                wbcs_pkg::REG_HEIGHT: height_reg <= wbcs_pkg::DIM_BITS'(cfg_data);
                default: ;
            endcase
            state_reg <= SET_PROD;
        end else begin
            unique case (state_reg)
                SET_IDLE: ;
                SET_PROD: begin
                    total_reg <= wbcs_pkg::IDX_W'(width_reg) * wbcs_pkg::IDX_W'(height_reg);
                    state_reg <= SET_LO;
                end
                SET_LO: begin
                    band_lo_reg <= div3_out;
                    state_reg   <= SET_HI;
                end
                SET_HI: begin
                    band_hi_reg <= div3_out;
                    state_reg   <= SET_WLO;
                end
                SET_WLO: begin
                    width_lo_reg <= wbcs_pkg::DIM_BITS'(div3_out);
                    state_reg    <= SET_WHI;
                end
                SET_WHI: begin
                    width_hi_reg <= wbcs_pkg::DIM_BITS'(div3_out);
                    state_reg    <= SET_IDLE;
                end
                default: state_reg <= SET_PROD;
            endcase
        end
    end

    assign status.busy     = (state_reg != SET_IDLE);
    assign status.width    = width_reg;
    assign status.band_lo  = band_lo_reg;
    assign status.band_hi  = band_hi_reg;
    assign status.width_lo = width_lo_reg;
    assign status.width_hi = width_hi_reg;

endmodule

FILE: rtl/wbcs_front.sv
module wbcs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wbcs_pkg::CH_W-1:0]     red,
    input  logic [wbcs_pkg::CH_W-1:0]     green,
    input  logic [wbcs_pkg::CH_W-1:0]     blue,
    input  logic                          frame_end,
    input  wbcs_pkg::cfg_status_t         status,
    input  logic                          q_full,
    output logic                          q_push,
    output wbcs_pkg::pixel_t              q_item
);

    logic [wbcs_pkg::IDX_W-1:0]       pix_idx_reg;
    logic [wbcs_pkg::IDX_W-1:0]       pix_idx_next;
    logic [wbcs_pkg::DIM_BITS-1:0]    col_reg;
    logic [wbcs_pkg::DIM_BITS-1:0]    col_next;
    logic [wbcs_pkg::DIM_BITS:0]      col_inc;
    logic                             white;
    logic                             in_band;

    assign s_tready = !status.busy && !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Classify the pixel against the middle band
    always_comb begin
        white   = (red == wbcs_pkg::WHITE_LEVEL) && (green == wbcs_pkg::WHITE_LEVEL) &&
                  (blue == wbcs_pkg::WHITE_LEVEL);
        in_band = (pix_idx_reg >= status.band_lo) && (pix_idx_reg < status.band_hi);
        q_item.hit    = white && in_band;
        q_item.column = col_reg;
        q_item.last   = frame_end;
    end

    // Raster position: saturating index, column wrapping at the width
    always_comb begin
        pix_idx_next = (pix_idx_reg != '1) ? pix_idx_reg + 1'b1 : pix_idx_reg;
        col_inc      = {1'b0, col_reg} + 1'b1;
        col_next     = (col_inc >= {1'b0, status.width}) ? '0
                                                         : col_inc[wbcs_pkg::DIM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_idx_reg <= '0;
            col_reg     <= '0;
        end else if (q_push) begin
            if (frame_end) begin
                pix_idx_reg <= '0;
                col_reg     <= '0;
            end else begin
                pix_idx_reg <= pix_idx_next;
                col_reg     <= col_next;
            end
        end
    end

endmodule

FILE: rtl/wbcs_fifo.sv
module wbcs_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  wbcs_pkg::pixel_t      push_item,
    input  logic                  pop,
    output wbcs_pkg::pixel_t      head,
    output logic                  full,
    output logic                  empty
);

    wbcs_pkg::pixel_t                 slot_reg [wbcs_pkg::QUEUE_DEPTH];
    logic [wbcs_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [wbcs_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [wbcs_pkg::QPTR_W:0]        fill_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (fill_reg == (wbcs_pkg::QPTR_W+1)'(wbcs_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/wbcs_back.sv
module wbcs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  wbcs_pkg::pixel_t              q_head,
    output logic                          q_pop,
    input  wbcs_pkg::cfg_status_t         status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wbcs_pkg::DIR_W-1:0]    direction,
    output logic [wbcs_pkg::MEAN_W-1:0]   mean_column,
    output logic [wbcs_pkg::COUNT_W-1:0]  white_count
);

    typedef enum logic {
        BK_ACCUM,
        BK_DIVIDE
    } back_state_t;

    back_state_t                        state_reg;
    logic [wbcs_pkg::SUM_W-1:0]         sum_reg;
    logic [wbcs_pkg::IDX_W-1:0]         total_reg;
    logic [wbcs_pkg::SUM_W-1:0]         dvd_reg;
    logic [wbcs_pkg::IDX_W-1:0]         dvs_reg;
    logic [wbcs_pkg::IDX_W-1:0]         rem_reg;
    logic [wbcs_pkg::STEP_W-1:0]        step_reg;
    logic                               m_valid_reg;
    logic [wbcs_pkg::DIR_W-1:0]         dir_reg;
    logic [wbcs_pkg::MEAN_W-1:0]        mean_reg;
    logic [wbcs_pkg::COUNT_W-1:0]       count_reg;

    logic [wbcs_pkg::SUM_W-1:0]         sum_acc;
    logic [wbcs_pkg::IDX_W-1:0]         total_acc;
    logic [wbcs_pkg::IDX_W:0]           rem_sh;
    logic [wbcs_pkg::IDX_W:0]           rem_sub;
    logic                               ge;
    logic [wbcs_pkg::IDX_W-1:0]         rem_new;
    logic [wbcs_pkg::SUM_W-1:0]         quo_new;
    logic [wbcs_pkg::DIR_W-1:0]         dir_new;

    // Pop a final pixel only once the output register can take the result
    assign q_pop = (state_reg == BK_ACCUM) && !q_empty &&
                   (!q_head.last || !m_valid_reg || m_tready);

    // Accumulate the column of each hit
    always_comb begin
        sum_acc   = sum_reg + (q_head.hit ? wbcs_pkg::SUM_W'(q_head.column) : '0);
        total_acc = total_reg + wbcs_pkg::IDX_W'(q_head.hit);
    end

    // One restoring division step per cycle
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[wbcs_pkg::SUM_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
        rem_new = ge ? rem_sub[wbcs_pkg::IDX_W-1:0] : rem_sh[wbcs_pkg::IDX_W-1:0];
        quo_new = {dvd_reg[wbcs_pkg::SUM_W-2:0], ge};
    end

    // Steering decision from the finished mean
    always_comb begin
        if (dvs_reg == '0) begin
            dir_new = wbcs_pkg::DIR_STOP;
        end else if (quo_new < wbcs_pkg::SUM_W'(status.width_lo)) begin
            dir_new = wbcs_pkg::DIR_LEFT;
        end else if (quo_new > wbcs_pkg::SUM_W'(status.width_hi)) begin
            dir_new = wbcs_pkg::DIR_RIGHT;
        end else begin
            dir_new = wbcs_pkg::DIR_STRAIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_ACCUM;
            sum_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                BK_ACCUM: begin
                    if (q_pop) begin
                        if (q_head.last) begin
                            dvd_reg   <= sum_acc;
                            dvs_reg   <= total_acc;
                            rem_reg   <= '0;
                            step_reg  <= wbcs_pkg::STEP_W'(wbcs_pkg::SUM_W);
                            sum_reg   <= '0;
                            total_reg <= '0;
                            state_reg <= BK_DIVIDE;
                        end else begin
                            sum_reg   <= sum_acc;
                            total_reg <= total_acc;
                        end
                    end
                end
                BK_DIVIDE: begin
                    rem_reg  <= rem_new;
                    dvd_reg  <= quo_new;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == wbcs_pkg::STEP_W'(1)) begin
                        dir_reg     <= dir_new;
                        mean_reg    <= (dvs_reg == '0) ? '0 : wbcs_pkg::MEAN_W'(quo_new);
                        count_reg   <= wbcs_pkg::COUNT_W'(dvs_reg);
                        m_valid_reg <= 1'b1;
                        state_reg   <= BK_ACCUM;
                    end
                end
                default: state_reg <= BK_ACCUM;
            endcase
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign direction   = dir_reg;
    assign mean_column = mean_reg;
    assign white_count = count_reg;

endmodule
